// ----- hdl/cable_anchor_step_scheduler_unit_defines.svh -----
// Assertion macros for the cable anchor step scheduler.
`ifndef CABLE_ANCHOR_STEP_SCHEDULER_UNIT_DEFINES_SVH
`define CABLE_ANCHOR_STEP_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CASS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CASS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cass_pkg.sv -----
// Shared types and constants of the cable anchor step scheduler.
package cass_pkg;

  localparam int FRACTION_BITS_DEF   = 8;
  localparam int COORDINATE_BITS_DEF = 24;
  localparam int STEP_COUNT_BITS_DEF = 40;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_MOVE = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  localparam logic [2:0] REG_ANCHOR_X   = 3'd0;
  localparam logic [2:0] REG_ANCHOR_Y   = 3'd1;
  localparam logic [2:0] REG_ANCHOR_Z   = 3'd2;
  localparam logic [2:0] REG_STEPS      = 3'd3;
  localparam logic [2:0] REG_MICROSTEPS = 3'd4;
  localparam logic [2:0] REG_PRECISION  = 3'd5;

  localparam logic [15:0] STEPS_RESET      = 16'd200;
  localparam logic [8:0]  MICROSTEPS_RESET = 9'd16;
  localparam logic [15:0] PRECISION_RESET  = 16'd26;

  typedef struct packed {
    logic       load;
    logic       sq;
    logic [1:0] sq_idx;
    logic       sqrt;
    logic       root_rnd;
    logic       wr_len;
    logic       diff;
    logic       div;
    logic       mulp;
    logic       mulspc;
    logic       mulmf;
    logic       tick;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic prec_zero;
    logic out_busy;
  } status_t;

endpackage

// ----- hdl/cass_ctrl.sv -----
// Sequencer of the cable anchor step scheduler.
module cass_ctrl #(
  parameter int COORDINATE_BITS = cass_pkg::COORDINATE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  cass_pkg::status_t   status,
  output cass_pkg::cmd_t      cmd
);
  import cass_pkg::*;

  localparam int RW    = COORDINATE_BITS + 2;
  localparam int DISTW = RW + 1;
  localparam int DW    = ((DISTW > 32) ? DISTW : 32) + 1;
  localparam int NUMW  = DW + 3;
  localparam int MAXIT = (NUMW > 32) ? NUMW : 32;
  localparam int CNTW  = $clog2(MAXIT);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_SQ     = 12'b000000000010,
    S_SQRT   = 12'b000000000100,
    S_DIST   = 12'b000000001000,
    S_WRLEN  = 12'b000000010000,
    S_DIFF   = 12'b000000100000,
    S_DIV    = 12'b000001000000,
    S_MULP   = 12'b000010000000,
    S_MULSPC = 12'b000100000000,
    S_MULMF  = 12'b001000000000,
    S_TICK   = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_t;

  state_t            state, state_next;
  logic [CNTW-1:0]   cnt, cnt_next;
  logic              init_op;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          case (opcode)
            OP_INIT, OP_MOVE: state_next = S_SQ;
            OP_TICK:          state_next = S_TICK;
            default:          state_next = S_EMIT;
          endcase
        end
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        cmd.sq_idx = cnt[1:0];
        if (cnt == CNTW'(3)) state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt = 1'b1;
        if (cnt == CNTW'(RW - 1)) state_next = S_DIST;
      end
      S_DIST: begin
        cmd.root_rnd = 1'b1;
        state_next   = init_op ? S_WRLEN : S_DIFF;
      end
      S_WRLEN: begin
        cmd.wr_len = 1'b1;
        state_next = S_EMIT;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = status.prec_zero ? S_MULSPC : S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (cnt == CNTW'(NUMW - 1)) state_next = S_MULP;
      end
      S_MULP: begin
        cmd.mulp   = 1'b1;
        state_next = S_MULSPC;
      end
      S_MULSPC: begin
        cmd.mulspc = 1'b1;
        state_next = S_MULMF;
      end
      S_MULMF: begin
        cmd.mulmf  = 1'b1;
        state_next = S_EMIT;
      end
      S_TICK: begin
        cmd.tick = 1'b1;
        if (cnt == CNTW'(31)) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cnt_next = (state_next != state) ? '0 : cnt + CNTW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) init_op <= (opcode == OP_INIT);
  end

endmodule

// ----- hdl/cass_datapath.sv -----
// Datapath of the cable anchor step scheduler: config, state and arithmetic.
`include "cable_anchor_step_scheduler_unit_defines.svh"
module cass_datapath #(
  parameter int FRACTION_BITS   = cass_pkg::FRACTION_BITS_DEF,
  parameter int COORDINATE_BITS = cass_pkg::COORDINATE_BITS_DEF,
  parameter int STEP_COUNT_BITS = cass_pkg::STEP_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [2:0]                        cfg_index,
  input  logic [((COORDINATE_BITS > 16) ? COORDINATE_BITS : 16)-1:0] cfg_data,
  input  logic [1:0]                        opcode,
  input  logic signed [COORDINATE_BITS-1:0] pos_x,
  input  logic signed [COORDINATE_BITS-1:0] pos_y,
  input  logic signed [COORDINATE_BITS-1:0] pos_z,
  input  logic [31:0]                       elapsed_ms,
  input  logic [31:0]                       budget_ms,
  input  cass_pkg::cmd_t                    cmd,
  output cass_pkg::status_t                 status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              step_pulse,
  output logic                              direction,
  output logic [STEP_COUNT_BITS-1:0]        steps_remaining
);
  import cass_pkg::*;

  localparam int C     = COORDINATE_BITS;
  localparam int SB    = STEP_COUNT_BITS;
  localparam int DXW   = C + 1;
  localparam int RW    = C + 2;
  localparam int SUMW  = 2 * RW;
  localparam int REMW  = RW + 3;
  localparam int DISTW = RW + 1;
  localparam int DW    = ((DISTW > 32) ? DISTW : 32) + 1;
  localparam int MAGW  = DW + 1;
  localparam int NUMW  = MAGW + 2;
  localparam int STW   = MAGW + 16 - FRACTION_BITS;
  localparam int MFW   = STW + 9;
  localparam int TDW   = 32 + SB + 2;

  // configuration
  logic signed [C-1:0] ax, ay, az;
  logic [15:0]         spc, prec;
  logic [8:0]          mf;

  // architectural state
  logic [31:0]         spooled;
  logic [SB-1:0]       total, done;
  logic                dir;

  // work registers
  logic [1:0]          opc;
  logic signed [C-1:0] px, py, pz;
  logic [31:0]         te, tb;
  logic                bzero;
  logic [2*DXW-1:0]    prod;
  logic [SUMW-1:0]     rad;
  logic [REMW-1:0]     rem;
  logic [RW-1:0]       root;
  logic [DISTW-1:0]    root_rnd;
  logic [MAGW-1:0]     mag;
  logic [NUMW-1:0]     dnum;
  logic [17:0]         drem;
  logic [STW-1:0]      steps;
  logic signed [TDW-1:0] tacc;

  // combinational
  logic signed [C-1:0] pa, aa;
  logic signed [C+1:0] sdiff;
  logic [DXW-1:0]      adiff;
  logic [2*DXW-1:0]    sq;
  logic [REMW-1:0]     remsh, trial;
  logic signed [DW-1:0] delta;
  logic                neg;
  logic [DW-1:0]       magd;
  logic [17:0]         dt, den;
  logic [NUMW+15:0]    p_prod;
  logic [MAGW+15:0]    spc_prod;
  logic [MFW-1:0]      mf_prod;
  logic                tick_pulse;
  logic [SB-1:0]       done_n;

  function automatic logic signed [31:0] spooled_s(input logic [31:0] v);
    spooled_s = $signed(v);
  endfunction

  always_comb begin
    case (cmd.sq_idx)
      2'd0:    begin pa = px; aa = ax; end
      2'd1:    begin pa = py; aa = ay; end
      default: begin pa = pz; aa = az; end
    endcase
  end

  assign sdiff = (C+2)'(pa) - (C+2)'(aa);
  assign adiff = sdiff[C+1] ? DXW'(-sdiff) : DXW'(sdiff);
  assign sq    = adiff * adiff;

  assign remsh = {rem[REMW-3:0], rad[SUMW-1:SUMW-2]};
  assign trial = REMW'({root, 2'b01});

  assign delta = DW'($signed({1'b0, root_rnd})) - DW'(spooled_s(spooled));
  assign neg   = delta[DW-1];
  assign magd  = neg ? DW'(-delta) : DW'(delta);

  assign dt  = {drem[16:0], dnum[NUMW-1]};
  assign den = {1'b0, prec, 1'b0};

  assign p_prod   = dnum * prec;
  assign spc_prod = mag * spc;
  assign mf_prod  = steps * mf;

  assign tick_pulse = (opc == OP_TICK) && (done < total) &&
                      (bzero || (!tacc[TDW-1] && (|tacc)));
  assign done_n     = done + SB'(tick_pulse);

  assign status.prec_zero = (prec == 16'd0);
  assign status.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax   <= '0;
      ay   <= '0;
      az   <= '0;
      spc  <= STEPS_RESET;
      mf   <= MICROSTEPS_RESET;
      prec <= PRECISION_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ANCHOR_X:   ax   <= cfg_data[C-1:0];
        REG_ANCHOR_Y:   ay   <= cfg_data[C-1:0];
        REG_ANCHOR_Z:   az   <= cfg_data[C-1:0];
        REG_STEPS:      spc  <= cfg_data[15:0];
        REG_MICROSTEPS: mf   <= cfg_data[8:0];
        REG_PRECISION:  prec <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opc   <= opcode;
      px    <= pos_x;
      py    <= pos_y;
      pz    <= pos_z;
      te    <= elapsed_ms;
      tb    <= budget_ms;
      bzero <= (budget_ms == 32'd0);
      prod  <= '0;
      rad   <= '0;
      rem   <= '0;
      root  <= '0;
      tacc  <= '0;
    end
    if (cmd.sq) begin
      prod <= sq;
      rad  <= rad + SUMW'(prod);
    end
    if (cmd.sqrt) begin
      rad <= {rad[SUMW-3:0], 2'b00};
      if (remsh >= trial) begin
        rem  <= remsh - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= remsh;
        root <= {root[RW-2:0], 1'b0};
      end
    end
    if (cmd.root_rnd) root_rnd <= DISTW'(root) + DISTW'(rem > REMW'(root));
    if (cmd.diff) begin
      mag  <= MAGW'(magd);
      dnum <= (NUMW'(magd) << 1) + NUMW'(prec);
      drem <= '0;
    end
    if (cmd.div) begin
      if (dt >= den) begin
        drem <= dt - den;
        dnum <= {dnum[NUMW-2:0], 1'b1};
      end else begin
        drem <= dt;
        dnum <= {dnum[NUMW-2:0], 1'b0};
      end
    end
    if (cmd.mulp)   mag   <= MAGW'(p_prod);
    if (cmd.mulspc) steps <= STW'(spc_prod >> FRACTION_BITS);
    if (cmd.tick) begin
      tacc <= (tacc <<< 1) + (te[31] ? TDW'(total) : TDW'(0))
                           - (tb[31] ? TDW'(done) : TDW'(0));
      te   <= {te[30:0], 1'b0};
      tb   <= {tb[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spooled <= '0;
      total   <= '0;
      done    <= '0;
      dir     <= 1'b0;
    end else begin
      if (cmd.wr_len) spooled <= 32'(root_rnd);
      if (cmd.diff)   dir     <= neg;
      if (cmd.mulspc) spooled <= dir ? spooled - mag[31:0] : spooled + mag[31:0];
      if (cmd.mulmf) begin
        total <= (|(mf_prod >> SB)) ? '1 : SB'(mf_prod);
        done  <= '0;
      end
      if (cmd.emit) done <= done_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      step_pulse      <= tick_pulse;
      direction       <= dir;
      steps_remaining <= total - done_n;
    end
  end

  `CASS_ASSERT_IMP(a_pulse_below_total, cmd.emit && tick_pulse, done < total, "pulse at total")
  `CASS_ASSERT_NXT(a_move_clears_done, cmd.mulmf, done == '0, "move left done count")
  `CASS_ASSERT_NXT(a_emit_sets_valid, cmd.emit, out_valid, "result not presented")

endmodule

// ----- hdl/cable_anchor_step_scheduler_unit.sv -----
// Top level of the cable anchor step scheduler.
// One item is worked at a time by a sequencer over a shared datapath. A move
// runs squaring of the three anchor differences, a bit-pair square root,
// rounding, the difference from the spooled length, a restoring divide
// (skipped with the precision multiply when the precision is zero), the
// steps-per-revolution and microstep multiplies and a result step. An init
// item runs the squaring, root and rounding, then writes the spooled length
// and gives a result. A tick runs a bit-serial compare of elapsed*total
// against done*budget and gives a result. A finished result waits in the output
// register; the next item is accepted while it waits.
module cable_anchor_step_scheduler_unit #(
  parameter int FRACTION_BITS   = cass_pkg::FRACTION_BITS_DEF,
  parameter int COORDINATE_BITS = cass_pkg::COORDINATE_BITS_DEF,
  parameter int STEP_COUNT_BITS = cass_pkg::STEP_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [2:0]                        cfg_index,
  input  logic [((COORDINATE_BITS > 16) ? COORDINATE_BITS : 16)-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic signed [COORDINATE_BITS-1:0] pos_x,
  input  logic signed [COORDINATE_BITS-1:0] pos_y,
  input  logic signed [COORDINATE_BITS-1:0] pos_z,
  input  logic [31:0]                       elapsed_ms,
  input  logic [31:0]                       budget_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              step_pulse,
  output logic                              direction,
  output logic [STEP_COUNT_BITS-1:0]        steps_remaining
);
  import cass_pkg::*;

  cmd_t    cmd;
  status_t status;

  cass_ctrl #(
    .COORDINATE_BITS(COORDINATE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .status   (status),
    .cmd      (cmd)
  );

  cass_datapath #(
    .FRACTION_BITS  (FRACTION_BITS),
    .COORDINATE_BITS(COORDINATE_BITS),
    .STEP_COUNT_BITS(STEP_COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .elapsed_ms     (elapsed_ms),
    .budget_ms      (budget_ms),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .step_pulse     (step_pulse),
    .direction      (direction),
    .steps_remaining(steps_remaining)
  );

endmodule
